/* design/bfw_pkg.sv */
// Shared types and codes for the bilateral filter window unit.
package bfw_pkg;

  // Input function codes
  localparam logic [1:0] FN_PIXEL   = 2'd0;
  localparam logic [1:0] FN_FLUSH   = 2'd1;
  localparam logic [1:0] FN_RANGE   = 2'd2;
  localparam logic [1:0] FN_SPATIAL = 2'd3;

  // Job codes passed from the front to the back
  localparam logic [1:0] OP_PIX  = 2'd0;
  localparam logic [1:0] OP_EMIT = 2'd1;
  localparam logic [1:0] OP_RNG  = 2'd2;
  localparam logic [1:0] OP_SPA  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  localparam int ROW_W  = 12;
  localparam int COL_MW = 12;
  localparam int SLOT_MW = 4;
  localparam int HEIGHT_MAX = 4096;

  // One queued job: a table load, a pixel write, and/or one output to compute
  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         pixel;
    logic [7:0]         index;
    logic [15:0]        weight;
    logic [SLOT_MW-1:0] wslot;
    logic [COL_MW-1:0]  wcol;
    logic               emit;
    logic [ROW_W-1:0]   erow;
    logic [COL_MW-1:0]  ecol;
    logic [SLOT_MW-1:0] eslot;
    logic               last;
  } job_t;

endpackage

/* design/bilateral_filter_window_unit.sv */
// Top level of the bilateral filter window unit.
//
//  channel  direction  signals                                   transfer when
//  in       input      in_func/pixel_value/table_index/weight    in_valid & in_ready
//  out      output     out_filtered_value/row/col/frame_last     out_valid & out_ready
//  cfg      input      cfg_index, cfg_data                       cfg_we
//
//  Loads and pixels that make no output enter at one a cycle until the
//  four-entry job queue fills; the back retires them at one a cycle.
//  An output in the back takes one line store read per window tap, four
//  pipeline stages and eight divider steps.
//  Reset is synchronous; a width or height configuration write restarts the raster position.
//  A stalled output holds the back; the front keeps taking items until
//  the queue is full.
module bilateral_filter_window_unit #(
  parameter int WIN         = 5,
  parameter int MAX_WIDTH   = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_pixel_value,
  input  logic [7:0]  in_table_index,
  input  logic [15:0] in_table_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_filtered_value,
  output logic [11:0] out_row,
  output logic [9:0]  out_col,
  output logic        out_frame_last
);

  logic [10:0]   width_r, width_nxt;
  logic [12:0]   height_r, height_nxt;
  logic          restart;
  logic          q_push, q_full, q_pop, q_empty;
  bfw_pkg::job_t q_in, q_out;

  // Configuration registers, clamped to their legal range
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    restart    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        bfw_pkg::CFG_WIDTH: begin
          restart = 1'b1;
          if (cfg_data[10:0] == '0) begin
            width_nxt = 11'd1;
          end else if (cfg_data[10:0] > 11'(MAX_WIDTH)) begin
            width_nxt = 11'(MAX_WIDTH);
          end else begin
            width_nxt = cfg_data[10:0];
          end
        end
        bfw_pkg::CFG_HEIGHT: begin
          restart = 1'b1;
          if (cfg_data == '0) begin
            height_nxt = 13'd1;
          end else if (cfg_data > 13'(bfw_pkg::HEIGHT_MAX)) begin
            height_nxt = 13'(bfw_pkg::HEIGHT_MAX);
          end else begin
            height_nxt = cfg_data;
          end
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd640;
      height_r <= 13'd480;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  bfw_front #(.WIN(WIN), .MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .restart         (restart),
    .frame_width     (width_r),
    .frame_height    (height_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_pixel_value  (in_pixel_value),
    .in_table_index  (in_table_index),
    .in_table_weight (in_table_weight),
    .q_push          (q_push),
    .q_data          (q_in),
    .q_full          (q_full)
  );

  bfw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  bfw_back #(.WIN(WIN), .MAX_WIDTH(MAX_WIDTH), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .frame_width        (width_r),
    .frame_height       (height_r),
    .q_empty            (q_empty),
    .q_data             (q_out),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value),
    .out_row            (out_row),
    .out_col            (out_col),
    .out_frame_last     (out_frame_last)
  );

endmodule

/* design/bfw_queue.sv */
// Short job queue between the front and back parts.
module bfw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bfw_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output bfw_pkg::job_t pop_data,
  output logic          empty
);

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  bfw_pkg::job_t  mem_r [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == (PW+1)'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  // Pointer and fill count
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue pushed while full");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

/* design/bfw_front.sv */
// Front part: takes input items, tracks raster positions and queues jobs.
module bfw_front #(
  parameter int WIN       = 5,
  parameter int MAX_WIDTH = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          restart,
  input  logic [10:0]   frame_width,
  input  logic [12:0]   frame_height,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_func,
  input  logic [7:0]    in_pixel_value,
  input  logic [7:0]    in_table_index,
  input  logic [15:0]   in_table_weight,
  output logic          q_push,
  output bfw_pkg::job_t q_data,
  input  logic          q_full
);

  localparam int RU    = (WIN - 1) / 2;
  localparam int RD    = WIN - 1 - RU;
  localparam int SLOTS = WIN + 1;
  localparam int SLW   = $clog2(SLOTS);
  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int LAGW  = $clog2(RD * MAX_WIDTH + RD + 1);

  logic [11:0]     in_row_r, in_row_nxt, emit_row_r, emit_row_nxt;
  logic [COLW-1:0] in_col_r, in_col_nxt, emit_col_r, emit_col_nxt;
  logic [SLW-1:0]  in_slot_r, in_slot_nxt, emit_slot_r, emit_slot_nxt;
  logic [LAGW-1:0] cnt_r, cnt_nxt;
  logic            pend_r, pend_nxt;

  logic            accept, fresh, do_emit, last;
  logic [11:0]     ir, er;
  logic [COLW-1:0] ic, ec;
  logic [SLW-1:0]  is, es;
  logic [LAGW-1:0] cnt, lag;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign lag      = LAGW'(RD) * LAGW'(frame_width) + LAGW'(RD);

  // Classify the item and step the raster counters
  always_comb begin
    fresh = pend_r && (in_func == bfw_pkg::FN_PIXEL);
    ir  = fresh ? '0 : in_row_r;
    ic  = fresh ? '0 : in_col_r;
    is  = fresh ? '0 : in_slot_r;
    er  = fresh ? '0 : emit_row_r;
    ec  = fresh ? '0 : emit_col_r;
    es  = fresh ? '0 : emit_slot_r;
    cnt = fresh ? '0 : cnt_r;
    last = ({1'b0, er} == frame_height - 13'd1) &&
           (12'(ec) == 12'(frame_width) - 12'd1);

    in_row_nxt    = ir;
    in_col_nxt    = ic;
    in_slot_nxt   = is;
    emit_row_nxt  = er;
    emit_col_nxt  = ec;
    emit_slot_nxt = es;
    cnt_nxt       = cnt;
    pend_nxt      = fresh ? 1'b0 : pend_r;
    do_emit       = 1'b0;
    q_push        = 1'b0;

    q_data        = '0;
    q_data.pixel  = in_pixel_value;
    q_data.index  = in_table_index;
    q_data.weight = in_table_weight;
    q_data.wslot  = bfw_pkg::SLOT_MW'(is);
    q_data.wcol   = bfw_pkg::COL_MW'(ic);
    q_data.erow   = er;
    q_data.ecol   = bfw_pkg::COL_MW'(ec);
    q_data.eslot  = bfw_pkg::SLOT_MW'(es);
    q_data.last   = last;

    unique case (in_func)
      bfw_pkg::FN_RANGE: begin
        q_data.op = bfw_pkg::OP_RNG;
        q_push    = accept;
      end
      bfw_pkg::FN_SPATIAL: begin
        q_data.op = bfw_pkg::OP_SPA;
        q_push    = accept && (in_table_index < 8'(WIN * WIN));
      end
      bfw_pkg::FN_FLUSH: begin
        q_data.op = bfw_pkg::OP_EMIT;
        do_emit   = pend_r;
        q_push    = accept && pend_r;
      end
      default: begin
        q_data.op = bfw_pkg::OP_PIX;
        q_push    = accept;
        do_emit   = (cnt >= lag);
        cnt_nxt   = (cnt < lag) ? cnt + 1'b1 : cnt;
        if (12'(ic) + 12'd1 >= 12'(frame_width)) begin
          in_col_nxt = '0;
          if (13'(ir) + 13'd1 >= frame_height) begin
            in_row_nxt  = '0;
            in_slot_nxt = '0;
            cnt_nxt     = '0;
            pend_nxt    = 1'b1;
          end else begin
            in_row_nxt  = ir + 1'b1;
            in_slot_nxt = (is == SLW'(SLOTS - 1)) ? '0 : is + 1'b1;
          end
        end else begin
          in_col_nxt = ic + 1'b1;
        end
      end
    endcase
    q_data.emit = do_emit;

    // Advance the output position
    if (do_emit) begin
      if (last) begin
        emit_row_nxt  = '0;
        emit_col_nxt  = '0;
        emit_slot_nxt = '0;
        pend_nxt      = 1'b0;
      end else if (12'(ec) + 12'd1 >= 12'(frame_width)) begin
        emit_col_nxt  = '0;
        emit_row_nxt  = er + 1'b1;
        emit_slot_nxt = (es == SLW'(SLOTS - 1)) ? '0 : es + 1'b1;
      end else begin
        emit_col_nxt = ec + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_row_r    <= '0;
      in_col_r    <= '0;
      in_slot_r   <= '0;
      emit_row_r  <= '0;
      emit_col_r  <= '0;
      emit_slot_r <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
    end else if (accept) begin
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      in_slot_r   <= in_slot_nxt;
      emit_row_r  <= emit_row_nxt;
      emit_col_r  <= emit_col_nxt;
      emit_slot_r <= emit_slot_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
    end
  end

endmodule

/* design/bfw_back.sv */
// Back part: weight tables, line store, window accumulation and division.
module bfw_back #(
  parameter int WIN         = 5,
  parameter int MAX_WIDTH   = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [10:0]   frame_width,
  input  logic [12:0]   frame_height,
  input  logic          q_empty,
  input  bfw_pkg::job_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_filtered_value,
  output logic [11:0]   out_row,
  output logic [9:0]    out_col,
  output logic          out_frame_last
);

  localparam int RU    = (WIN - 1) / 2;
  localparam int SLOTS = WIN + 1;
  localparam int SLW   = $clog2(SLOTS);
  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int AW    = $clog2(SLOTS * MAX_WIDTH);
  localparam int TAPS  = WIN * WIN;
  localparam int MW    = $clog2(TAPS);
  localparam int WIW   = $clog2(WIN);
  localparam int WSB   = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int DENW  = 2 * WSB + $clog2(TAPS);
  localparam int NUMW  = DENW + 8;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CEN  = 4'd1;
  localparam logic [3:0] ST_CENW = 4'd2;
  localparam logic [3:0] ST_ACC  = 4'd3;
  localparam logic [3:0] ST_DRN  = 4'd4;
  localparam logic [3:0] ST_DIVI = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_OUT  = 4'd7;

  logic [3:0]      state_r, state_nxt;
  logic [11:0]     erow_r;
  logic [COLW-1:0] ecol_r;
  logic [SLW-1:0]  eslot_r;
  logic            last_r;
  logic [7:0]      g_r;
  logic [WIW-1:0]  mrow_r, mcol_r;
  logic [MW-1:0]   m_r;
  logic [SLW-1:0]  nslot_r;
  logic [1:0]      drn_r;
  logic [2:0]      bit_r;
  logic [NUMW-1:0] num_r, rem_r;
  logic [DENW-1:0] den_r;
  logic [7:0]      quo_r;

  // Stores
  logic [7:0]      line_mem [SLOTS * MAX_WIDTH];
  logic [7:0]      lin_q;
  logic [WSB-1:0]  rng_mem [256];
  logic [WSB-1:0]  rng_q;
  logic [WSB-1:0]  sp_r [TAPS];

  // Window pipeline
  logic            p1_v_r, p2_v_r, p3_v_r, p4_v_r;
  logic [MW-1:0]   p1_m_r;
  logic [7:0]      p2_pix_r, p3_pix_r;
  logic [WSB-1:0]  p2_sw_r;
  logic [2*WSB-1:0] p3_w_r, p4_w_r;
  logic [2*WSB+7:0] p4_wv_r;

  logic            out_valid_r;
  logic [7:0]      out_val_r;
  logic [11:0]     out_row_r;
  logic [9:0]      out_col_r;
  logic            out_last_r;

  logic            pop_job, tap_valid, lin_we;
  logic [13:0]     nr, nc;
  logic [AW-1:0]   lin_waddr, lin_raddr;
  logic [7:0]      dif;
  logic [NUMW-1:0] trial;
  logic [SLW-1:0]  start_slot;

  assign pop_job = (state_r == ST_IDLE) && !q_empty;
  assign q_pop   = pop_job;

  // Neighbor position and frame bounds
  always_comb begin
    nr = 14'(erow_r) - 14'(RU) + 14'(mrow_r);
    nc = 14'(ecol_r) - 14'(RU) + 14'(mcol_r);
    tap_valid = (state_r == ST_ACC) && !nr[13] && !nc[13] &&
                (nr[12:0] < frame_height) && (nc[12:0] < 13'(frame_width));
    // Slot of the top window row, RU rows above the output row
    start_slot = (eslot_r >= SLW'(RU)) ? eslot_r - SLW'(RU) :
                 eslot_r + SLW'(SLOTS - RU);
    lin_we    = pop_job && (q_data.op == bfw_pkg::OP_PIX);
    lin_waddr = AW'(SLW'(q_data.wslot)) * AW'(MAX_WIDTH) + AW'(COLW'(q_data.wcol));
    if (state_r == ST_CEN) begin
      lin_raddr = AW'(eslot_r) * AW'(MAX_WIDTH) + AW'(ecol_r);
    end else begin
      lin_raddr = AW'(nslot_r) * AW'(MAX_WIDTH) + AW'(COLW'(nc));
    end
    dif   = (g_r > lin_q) ? g_r - lin_q : lin_q - g_r;
    trial = NUMW'(den_r) << bit_r;
  end

  // Line store
  always_ff @(posedge clk) begin
    if (lin_we) begin
      line_mem[lin_waddr] <= q_data.pixel;
    end
    lin_q <= line_mem[lin_raddr];
  end

  // Range weight table
  always_ff @(posedge clk) begin
    if (pop_job && (q_data.op == bfw_pkg::OP_RNG)) begin
      rng_mem[q_data.index] <= q_data.weight[WSB-1:0];
    end
    rng_q <= rng_mem[dif];
  end

  // Spatial weights
  always_ff @(posedge clk) begin
    if (pop_job && (q_data.op == bfw_pkg::OP_SPA)) begin
      sp_r[q_data.index[MW-1:0]] <= q_data.weight[WSB-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_job && q_data.emit) begin
          state_nxt = ST_CEN;
        end
      end
      ST_CEN:  state_nxt = ST_CENW;
      ST_CENW: state_nxt = ST_ACC;
      ST_ACC: begin
        if (m_r == MW'(TAPS - 1)) begin
          state_nxt = ST_DRN;
        end
      end
      ST_DRN: begin
        if (drn_r == '0) begin
          state_nxt = ST_DIVI;
        end
      end
      ST_DIVI: state_nxt = ST_DIV;
      ST_DIV: begin
        if (bit_r == '0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Job context, window counters and divider
  always_ff @(posedge clk) begin
    if (pop_job) begin
      erow_r  <= q_data.erow;
      ecol_r  <= COLW'(q_data.ecol);
      eslot_r <= SLW'(q_data.eslot);
      last_r  <= q_data.last;
    end
    if (state_r == ST_CENW) begin
      g_r     <= lin_q;
      mrow_r  <= '0;
      mcol_r  <= '0;
      m_r     <= '0;
      nslot_r <= start_slot;
      num_r   <= '0;
      den_r   <= '0;
    end
    if (state_r == ST_ACC) begin
      m_r <= m_r + 1'b1;
      if (mcol_r == WIW'(WIN - 1)) begin
        mcol_r  <= '0;
        mrow_r  <= mrow_r + 1'b1;
        nslot_r <= (nslot_r == SLW'(SLOTS - 1)) ? '0 : nslot_r + 1'b1;
      end else begin
        mcol_r <= mcol_r + 1'b1;
      end
      drn_r <= 2'd3;
    end
    if (state_r == ST_DRN) begin
      drn_r <= drn_r - 1'b1;
    end
    if (p4_v_r) begin
      num_r <= num_r + NUMW'(p4_wv_r);
      den_r <= den_r + DENW'(p4_w_r);
    end
    if (state_r == ST_DIVI) begin
      rem_r <= num_r;
      bit_r <= 3'd7;
      quo_r <= '0;
    end
    // Restoring division, one quotient bit a cycle
    if (state_r == ST_DIV) begin
      bit_r <= bit_r - 1'b1;
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        quo_r <= {quo_r[6:0], 1'b1};
      end else begin
        quo_r <= {quo_r[6:0], 1'b0};
      end
    end
  end

  // Tap pipeline: read, range lookup, weight product, pixel product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
    end else begin
      p1_v_r <= tap_valid;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_m_r   <= m_r;
    p2_pix_r <= lin_q;
    p2_sw_r  <= sp_r[p1_m_r];
    p3_pix_r <= p2_pix_r;
    p3_w_r   <= p2_sw_r * rng_q;
    p4_w_r   <= p3_w_r;
    p4_wv_r  <= p3_w_r * p3_pix_r;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_OUT) && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && (!out_valid_r || out_ready)) begin
      out_val_r  <= (den_r == '0) ? 8'd0 : quo_r;
      out_row_r  <= erow_r;
      out_col_r  <= 10'(ecol_r);
      out_last_r <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_val_r;
  assign out_row            = out_row_r;
  assign out_col            = out_col_r;
  assign out_frame_last     = out_last_r;

  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !(p1_v_r || p2_v_r || p3_v_r || p4_v_r))
    else $error("tap pipeline busy outside a window pass");
  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVI) |-> (den_r != '0 || num_r == '0))
    else $error("numerator without weight");
  a_div_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (rem_r < NUMW'(den_r) || den_r == '0))
    else $error("quotient exceeds eight bits");
  a_taps_only_acc: assert property (@(posedge clk) disable iff (!rst_n)
    p1_v_r |-> ($past(state_r) == ST_ACC))
    else $error("tap issued outside window pass");

endmodule
